// ===== hdl/sds_pkg.sv =====
package sds_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    typedef logic [2:0] dir_t;

    localparam dir_t DIR_NONE  = 3'd0;
    localparam dir_t DIR_UP    = 3'd1;
    localparam dir_t DIR_DOWN  = 3'd2;
    localparam dir_t DIR_LEFT  = 3'd3;
    localparam dir_t DIR_RIGHT = 3'd4;

    typedef struct packed {
        logic load_in;
        logic close_step;
        logic flush_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic emit_close;
        logic emit_flush;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

// ===== hdl/sds_div.sv =====
module sds_div #(
    parameter int DIVIDEND_BITS = 32,
    parameter int DIVISOR_BITS  = 16,
    parameter int QUOT_BITS     = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [QUOT_BITS-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);
    localparam logic [CNT_W-1:0] ITERS = CNT_W'(DIVIDEND_BITS);

    logic                     busy_reg;
    logic [CNT_W-1:0]         iter_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  den_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;
    logic [DIVISOR_BITS-1:0]  rem_next;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial    = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            iter_reg <= ITERS;
        end else if (busy_reg) begin
            iter_reg <= iter_reg - 1'b1;
            if (iter_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = ~busy_reg;
    assign quotient = quo_reg[QUOT_BITS-1:0];

endmodule

// ===== hdl/sds_datapath.sv =====
module sds_datapath #(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sds_pkg::cmd_t         cmd,
    output sds_pkg::status_t      st,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  logic                  in_down,
    input  logic                  in_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_dir,
    output logic                  m_drawn,
    output logic [COORD_BITS-1:0] m_x,
    output logic [COORD_BITS-1:0] m_y,
    output logic                  m_last
);
    import sds_pkg::*;

    localparam int SUM_BITS = COORD_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // latched request
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic                  pdown_reg, plast_reg;

    // path state
    logic                  have_prev_reg, have_prev_next;
    logic [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    dir_t                  run_dir_reg, run_dir_next;
    logic                  open_valid_reg, open_valid_next;
    dir_t                  open_dir_reg, open_dir_next;
    logic                  open_drawn_reg, open_drawn_next;
    logic [COORD_BITS-1:0] start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;
    logic [SUM_BITS-1:0]   sum_x_reg, sum_x_next;
    logic [SUM_BITS-1:0]   sum_y_reg, sum_y_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // segment being emitted
    dir_t                  snap_dir_reg;
    logic                  snap_drawn_reg;
    logic [COORD_BITS-1:0] snap_x_reg, snap_y_reg;
    logic                  snap_empty_reg;
    logic                  snap_last_reg;

    logic                  out_valid_reg;
    dir_t                  out_dir_reg;
    logic                  out_drawn_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                  out_last_reg;

    logic                  x_gt, y_gt;
    logic [COORD_BITS-1:0] ax, ay;
    dir_t                  step_dir;
    logic                  opens;
    logic [SUM_BITS-1:0]   acc_x, acc_y;
    logic [COUNT_BITS-1:0] acc_count;

    logic                  div_start;
    logic [SUM_BITS-1:0]   div_num_x, div_num_y;
    logic [COUNT_BITS-1:0] div_den;
    logic                  done_x, done_y;
    logic [COORD_BITS-1:0] quot_x, quot_y;

    // quantized motion from the previous pen-down point; ties go vertical
    always_comb begin
        x_gt     = px_reg > prev_x_reg;
        y_gt     = py_reg > prev_y_reg;
        ax       = x_gt ? px_reg - prev_x_reg : prev_x_reg - px_reg;
        ay       = y_gt ? py_reg - prev_y_reg : prev_y_reg - py_reg;
        step_dir = DIR_NONE;
        if (have_prev_reg && (ax != '0 || ay != '0)) begin
            if (ax > ay) begin
                step_dir = x_gt ? DIR_LEFT : DIR_RIGHT;
            end else begin
                step_dir = y_gt ? DIR_UP : DIR_DOWN;
            end
        end
        opens = (step_dir != DIR_NONE && step_dir != run_dir_reg) || !pdown_reg;
        if (count_reg != COUNT_MAX) begin
            acc_x     = sum_x_reg + SUM_BITS'(px_reg);
            acc_y     = sum_y_reg + SUM_BITS'(py_reg);
            acc_count = count_reg + 1'b1;
        end else begin
            acc_x     = sum_x_reg;
            acc_y     = sum_y_reg;
            acc_count = count_reg;
        end
    end

    always_comb begin
        have_prev_next  = have_prev_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        run_dir_next    = run_dir_reg;
        open_valid_next = open_valid_reg;
        open_dir_next   = open_dir_reg;
        open_drawn_next = open_drawn_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        count_next      = count_reg;
        div_start       = 1'b0;
        div_num_x       = acc_x;
        div_num_y       = acc_y;
        div_den         = acc_count;
        if (cmd.close_step) begin
            sum_x_next = acc_x;
            sum_y_next = acc_y;
            count_next = acc_count;
            if (opens) begin
                div_start       = open_valid_reg;
                open_valid_next = 1'b1;
                open_dir_next   = step_dir;
                open_drawn_next = pdown_reg;
                start_x_next    = px_reg;
                start_y_next    = py_reg;
                sum_x_next      = '0;
                sum_y_next      = '0;
                count_next      = '0;
                run_dir_next    = step_dir;
            end
            if (!pdown_reg) begin
                have_prev_next = 1'b0;
                run_dir_next   = DIR_NONE;
            end else begin
                have_prev_next = 1'b1;
                prev_x_next    = px_reg;
                prev_y_next    = py_reg;
            end
        end else if (cmd.flush_step && plast_reg) begin
            div_start       = open_valid_reg;
            div_num_x       = sum_x_reg;
            div_num_y       = sum_y_reg;
            div_den         = count_reg;
            have_prev_next  = 1'b0;
            prev_x_next     = '0;
            prev_y_next     = '0;
            run_dir_next    = DIR_NONE;
            open_valid_next = 1'b0;
            open_dir_next   = DIR_NONE;
            open_drawn_next = 1'b0;
            start_x_next    = '0;
            start_y_next    = '0;
            sum_x_next      = '0;
            sum_y_next      = '0;
            count_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg  <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            run_dir_reg    <= DIR_NONE;
            open_valid_reg <= 1'b0;
            open_dir_reg   <= DIR_NONE;
            open_drawn_reg <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            have_prev_reg  <= have_prev_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            run_dir_reg    <= run_dir_next;
            open_valid_reg <= open_valid_next;
            open_dir_reg   <= open_dir_next;
            open_drawn_reg <= open_drawn_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            count_reg      <= count_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            px_reg    <= in_x;
            py_reg    <= in_y;
            pdown_reg <= in_down;
            plast_reg <= in_last;
        end
        if (div_start) begin
            snap_dir_reg   <= open_dir_reg;
            snap_drawn_reg <= open_drawn_reg;
            snap_x_reg     <= start_x_reg;
            snap_y_reg     <= start_y_reg;
            snap_empty_reg <= div_den == '0;
            snap_last_reg  <= cmd.flush_step;
        end
        if (cmd.out_load) begin
            out_dir_reg   <= snap_dir_reg;
            out_drawn_reg <= snap_drawn_reg;
            out_x_reg     <= snap_empty_reg ? snap_x_reg : quot_x;
            out_y_reg     <= snap_empty_reg ? snap_y_reg : quot_y;
            out_last_reg  <= snap_last_reg;
        end
    end

    sds_div #(
        .DIVIDEND_BITS(SUM_BITS),
        .DIVISOR_BITS (COUNT_BITS),
        .QUOT_BITS    (COORD_BITS)
    ) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_num_x),
        .divisor (div_den),
        .done    (done_x),
        .quotient(quot_x)
    );

    sds_div #(
        .DIVIDEND_BITS(SUM_BITS),
        .DIVISOR_BITS (COUNT_BITS),
        .QUOT_BITS    (COORD_BITS)
    ) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_num_y),
        .divisor (div_den),
        .done    (done_y),
        .quotient(quot_y)
    );

    always_comb begin
        st.emit_close = opens && open_valid_reg;
        st.emit_flush = plast_reg && open_valid_reg;
        st.div_done   = done_x && done_y;
        st.out_busy   = out_valid_reg && !m_ready;
    end

    assign m_valid = out_valid_reg;
    assign m_dir   = out_dir_reg;
    assign m_drawn = out_drawn_reg;
    assign m_x     = out_x_reg;
    assign m_y     = out_y_reg;
    assign m_last  = out_last_reg;

endmodule

// ===== hdl/sds_ctrl.sv =====
module sds_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output sds_pkg::cmd_t    cmd,
    input  sds_pkg::status_t st
);
    import sds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_FLUSH,
        ST_DIV,
        ST_PUT
    } state_t;

    state_t state_reg, state_next;
    logic   resume_reg, resume_next;

    always_comb begin
        state_next     = state_reg;
        resume_next    = resume_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                cmd.close_step = 1'b1;
                resume_next    = 1'b1;
                state_next     = st.emit_close ? ST_DIV : ST_FLUSH;
            end
            ST_FLUSH: begin
                cmd.flush_step = 1'b1;
                resume_next    = 1'b0;
                state_next     = st.emit_flush ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (st.div_done) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (!st.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = resume_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            resume_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
        end
    end

endmodule

// ===== hdl/stroke_direction_segmenter.sv =====
// Four-direction chain coder for pen paths. Each accepted point is compared
// with the previous pen-down point and quantized to up, down, left or right
// (ties go vertical); a change of direction or a pen-up point closes the open
// segment, which is sent out with its direction, draw flag and the truncated
// mean of its points (its start point if it holds none). A point with s_tlast
// also flushes the open segment with m_tlast set and clears all path state,
// so one point can give zero, one or two results. Points are handled one at
// a time, and each result waits for the bit-serial dividers that form the x
// and y means in parallel. A finished result sits in the output register
// while the next point is taken in.
module stroke_direction_segmenter #(
    parameter int COORD_BITS = sds_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = sds_pkg::COUNT_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pos_x, pos_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // pen_down
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // seg_direction, seg_x, seg_y
    output logic [((3+2*COORD_BITS+7)/8)*8-1:0]  m_tdata,
    // seg_drawn
    output logic                                 m_tuser,
    output logic                                 m_tlast
);
    import sds_pkg::*;

    localparam int S_DATA_W = ((2*COORD_BITS+7)/8)*8;
    localparam int M_DATA_W = ((3+2*COORD_BITS+7)/8)*8;

    cmd_t                  cmd;
    status_t               st;
    logic [2:0]            seg_direction;
    logic [COORD_BITS-1:0] seg_x, seg_y;

    sds_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_tvalid),
        .s_ready(s_tready),
        .cmd    (cmd),
        .st     (st)
    );

    sds_datapath #(
        .COORD_BITS(COORD_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .st     (st),
        .in_x   (s_tdata[COORD_BITS-1:0]),
        .in_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_down(s_tuser),
        .in_last(s_tlast),
        .m_valid(m_tvalid),
        .m_ready(m_tready),
        .m_dir  (seg_direction),
        .m_drawn(m_tuser),
        .m_x    (seg_x),
        .m_y    (seg_y),
        .m_last (m_tlast)
    );

    assign m_tdata = M_DATA_W'({seg_y, seg_x, seg_direction});

endmodule

// ===== hdl/sds_checker.sv =====
module sds_checker #(
    parameter int S_W = 32,
    parameter int M_W = 40
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic [S_W-1:0] s_tdata,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [M_W-1:0] m_tdata,
    input logic           m_tuser,
    input logic           m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'd4)
        else $error("segment direction out of range");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one in work");

    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown(s_tdata))
        else $error("request data unknown when taken");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stroke_direction_segmenter sds_checker #(
    .S_W(S_DATA_W),
    .M_W(M_DATA_W)
) u_sds_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

// ===== verif/tb_stroke_direction_segmenter.sv =====
module tb_stroke_direction_segmenter;
    timeunit 1ns;
    timeprecision 1ps;
    import sds_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int NW = COUNT_BITS_DEF;
    localparam logic [NW-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          down;
        logic          last;
    } point_t;

    typedef struct packed {
        dir_t          dir;
        logic          drawn;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } seg_t;

    localparam int N_DIRECTED = 22;
    localparam point_t DIRECTED [N_DIRECTED] = '{
        '{16'd0,     16'd0,     1'b1, 1'b0},
        '{16'd0,     16'd100,   1'b1, 1'b0},
        '{16'd0,     16'd300,   1'b1, 1'b0},
        '{16'd0,     16'd500,   1'b1, 1'b0},
        '{16'd65535, 16'd500,   1'b1, 1'b0},
        '{16'd65535, 16'd500,   1'b1, 1'b1},
        '{16'd1234,  16'd4321,  1'b0, 1'b0},
        '{16'd7,     16'd9,     1'b0, 1'b1},
        '{16'd500,   16'd500,   1'b1, 1'b1},
        '{16'd100,   16'd100,   1'b1, 1'b0},
        '{16'd100,   16'd100,   1'b1, 1'b0},
        '{16'd110,   16'd90,    1'b1, 1'b0},
        '{16'd100,   16'd80,    1'b1, 1'b0},
        '{16'd90,    16'd70,    1'b1, 1'b0},
        '{16'd80,    16'd70,    1'b1, 1'b0},
        '{16'd0,     16'd65535, 1'b0, 1'b0},
        '{16'd65535, 16'd0,     1'b1, 1'b0},
        '{16'd65535, 16'd65535, 1'b1, 1'b1},
        '{16'd40000, 16'd40000, 1'b1, 1'b0},
        '{16'd39000, 16'd40000, 1'b1, 1'b0},
        '{16'd39000, 16'd39000, 1'b1, 1'b0},
        '{16'd39000, 16'd39000, 1'b1, 1'b1}
    };

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [((2*CW+7)/8)*8-1:0]          s_tdata  = '0;
    logic                               s_tuser  = 1'b0;
    logic                               s_tlast  = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [((3+2*CW+7)/8)*8-1:0]        m_tdata;
    logic                               m_tuser;
    logic                               m_tlast;

    int   errors     = 0;
    int   items_sent = 0;
    bit   quiet      = 1'b0;
    int   stall_left = 0;
    seg_t pending_segs [$];

    // chain coder state
    bit            prior_ok;
    logic [CW-1:0] prior_x, prior_y;
    dir_t          heading;
    bit            seg_open;
    dir_t          seg_dir;
    logic          seg_pen;
    logic [CW-1:0] seg_x0, seg_y0;
    logic [31:0]   acc_x, acc_y;
    logic [NW-1:0] acc_n;

    stroke_direction_segmenter #(
        .COORD_BITS(CW),
        .COUNT_BITS(NW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void clear_path();
        prior_ok = 1'b0;
        prior_x  = '0;
        prior_y  = '0;
        heading  = DIR_NONE;
        seg_open = 1'b0;
        seg_dir  = DIR_NONE;
        seg_pen  = 1'b0;
        seg_x0   = '0;
        seg_y0   = '0;
        acc_x    = '0;
        acc_y    = '0;
        acc_n    = '0;
    endfunction

    function automatic seg_t closed_seg(logic last);
        seg_t        s;
        logic [31:0] mx;
        logic [31:0] my;
        mx = 32'(seg_x0);
        my = 32'(seg_y0);
        if (acc_n != 0) begin
            mx = acc_x / 32'(acc_n);
            my = acc_y / 32'(acc_n);
        end
        s.dir   = seg_dir;
        s.drawn = seg_pen;
        s.x     = mx[CW-1:0];
        s.y     = my[CW-1:0];
        s.last  = last;
        return s;
    endfunction

    task automatic chain_code_point(input point_t p, output seg_t res [2], output int n);
        dir_t step;
        int   dx, dy, ax, ay;
        n    = 0;
        step = DIR_NONE;
        if (prior_ok) begin
            dx = int'(prior_x) - int'(p.x);
            dy = int'(prior_y) - int'(p.y);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            if (dx != 0 || dy != 0) begin
                if (ax > ay)
                    step = dx < 0 ? DIR_LEFT : DIR_RIGHT;
                else
                    step = dy < 0 ? DIR_UP : DIR_DOWN;
            end
        end
        if (acc_n != COUNT_SAT) begin
            acc_x += 32'(p.x);
            acc_y += 32'(p.y);
            acc_n++;
        end
        if ((step != DIR_NONE && step != heading) || !p.down) begin
            if (seg_open) begin
                res[n] = closed_seg(1'b0);
                n++;
            end
            seg_open = 1'b1;
            seg_dir  = step;
            seg_pen  = p.down;
            seg_x0   = p.x;
            seg_y0   = p.y;
            acc_x    = '0;
            acc_y    = '0;
            acc_n    = '0;
            heading  = step;
        end
        if (!p.down) begin
            prior_ok = 1'b0;
            heading  = DIR_NONE;
        end else begin
            prior_ok = 1'b1;
            prior_x  = p.x;
            prior_y  = p.y;
        end
        if (p.last) begin
            if (seg_open) begin
                res[n] = closed_seg(1'b1);
                n++;
            end
            clear_path();
        end
    endtask

    // hand-checked results for some directed rows
    function automatic bit typed_results(int row, output seg_t r [2], output int n);
        n = 0;
        case (row)
            5: begin
                n    = 1;
                r[0] = '{DIR_LEFT, 1'b1, 16'd65535, 16'd500, 1'b1};
            end
            7: begin
                n    = 2;
                r[0] = '{DIR_NONE, 1'b0, 16'd7, 16'd9, 1'b0};
                r[1] = '{DIR_NONE, 1'b0, 16'd7, 16'd9, 1'b1};
            end
            8: n = 0;
            17: begin
                n    = 2;
                r[0] = '{DIR_UP, 1'b0, 16'd65535, 16'd32767, 1'b0};
                r[1] = '{DIR_UP, 1'b1, 16'd65535, 16'd65535, 1'b1};
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic send_point(input point_t p);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.y, p.x};
        s_tuser  <= p.down;
        s_tlast  <= p.last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic apply_point(input point_t p);
        seg_t got [2];
        int   n;
        send_point(p);
        chain_code_point(p, got, n);
        for (int i = 0; i < n; i++)
            pending_segs = {pending_segs, got[i]};
    endtask

    task automatic random_path(input int len);
        point_t p;
        dir_t   d;
        int     lx, ly, step_len, side;
        lx = $urandom_range(0, 65535);
        ly = $urandom_range(0, 65535);
        d  = dir_t'($urandom_range(1, 4));
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0)
                d = dir_t'($urandom_range(1, 4));
            step_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 40);
            side = $urandom_range(0, step_len);
            if ($urandom_range(0, 1) == 1)
                side = -side;
            case (d)
                DIR_UP: begin
                    ly += step_len;
                    lx += side;
                end
                DIR_DOWN: begin
                    ly -= step_len;
                    lx += side;
                end
                DIR_LEFT: begin
                    lx += step_len;
                    ly += side;
                end
                default: begin
                    lx -= step_len;
                    ly += side;
                end
            endcase
            p.x    = lx[CW-1:0];
            p.y    = ly[CW-1:0];
            p.down = ($urandom_range(0, 11) != 0);
            p.last = (k == len - 1);
            apply_point(p);
        end
    endtask

    task automatic noise_points(input int cnt);
        point_t p;
        for (int k = 0; k < cnt; k++) begin
            p.x    = CW'($urandom_range(0, 65535));
            p.y    = CW'($urandom_range(0, 65535));
            p.down = 1'($urandom_range(0, 1));
            p.last = ($urandom_range(0, 7) == 0);
            apply_point(p);
        end
    endtask

    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        seg_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_segs.size() == 0) begin
                $error("result with no segment pending");
                errors++;
            end else begin
                want = pending_segs.pop_front();
                if (m_tdata[2:0] !== want.dir) begin
                    $error("seg_direction: expected %0d, actual %0d", want.dir, m_tdata[2:0]);
                    errors++;
                end
                if (m_tuser !== want.drawn) begin
                    $error("seg_drawn: expected %0d, actual %0d", want.drawn, m_tuser);
                    errors++;
                end
                if (m_tdata[3 +: CW] !== want.x) begin
                    $error("seg_x: expected %0d, actual %0d", want.x, m_tdata[3 +: CW]);
                    errors++;
                end
                if (m_tdata[3+CW +: CW] !== want.y) begin
                    $error("seg_y: expected %0d, actual %0d", want.y, m_tdata[3+CW +: CW]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("seg_last: expected %0d, actual %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        seg_t   got [2];
        seg_t   typed [2];
        int     n, tn, sat_end;
        clear_path();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_point(DIRECTED[i]);
            chain_code_point(DIRECTED[i], got, n);
            if (typed_results(i, typed, tn)) begin
                for (int k = 0; k < tn; k++)
                    pending_segs = {pending_segs, typed[k]};
            end else begin
                for (int k = 0; k < n; k++)
                    pending_segs = {pending_segs, got[k]};
            end
        end

        while (items_sent < 600) begin
            if ($urandom_range(0, 6) == 0)
                noise_points($urandom_range(1, 4));
            else
                random_path($urandom_range(1, 14));
        end

        quiet = 1'b1;

        sat_end = items_sent;
        while (items_sent < sat_end + 100)
            random_path($urandom_range(1, 14));
        s_tvalid <= 1'b0;

        while (pending_segs.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

endmodule
